FILE: rtl/core/pal_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pal_pkg - shared types and constants of the positional array list
// Sizes, command and status codes, request and response structs, cell control.
// ----------------------------------------------------------------------------
package pal_pkg;

   localparam int CAPACITY   = 128;
   localparam int DATA_WIDTH = 32;

   // count holds 0..CAPACITY, an index 0..CAPACITY-1
   localparam int CNT_W = $clog2(CAPACITY + 1);
   // compare width covering both the 8-bit position and the count
   localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

   // read gather: first level ORs GROUP_SIZE cells into one register
   localparam int GROUP_SIZE = 16;
   localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

   typedef logic [DATA_WIDTH-1:0] data_type;
   typedef logic [GROUP_SIZE-1:0][DATA_WIDTH-1:0] group_terms_type;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_READ   = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GATHER,
      ST_COMBINE
   } state_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [7:0]         position;
      logic signed [31:0] value_in;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [6:0]         moved;
      logic [7:0]         count;
      logic signed [31:0] value_out;
   } rsp_type;

   // per-cell control from the list controller
   typedef struct packed {
      logic load;       // take the request value
      logic from_below; // take the neighbour one index lower (insert shift)
      logic from_above; // take the neighbour one index higher (delete shift)
      logic sel;        // drive stored entry onto the read gather
   } cell_ctrl_type;

endpackage
`default_nettype wire

FILE: rtl/core/pal_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pal_cell - one storage cell of the list chain
// Holds one entry and loads from the request or from either neighbour.
// ----------------------------------------------------------------------------
module pal_cell (
   input  wire logic                   clock,
   input  wire pal_pkg::cell_ctrl_type ctrl,
   input  wire pal_pkg::data_type      value,
   input  wire pal_pkg::data_type      below,
   input  wire pal_pkg::data_type      above,
   output pal_pkg::data_type           data,
   output pal_pkg::data_type           read_term
);

   pal_pkg::data_type data_ff;

   // entry register, no reset: contents beyond the count are don't-care
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         data_ff <= value;
      end else if (ctrl.from_below) begin
         data_ff <= below;
      end else if (ctrl.from_above) begin
         data_ff <= above;
      end
   end

   assign data      = data_ff;
   assign read_term = ctrl.sel ? data_ff : '0;

endmodule
`default_nettype wire

FILE: rtl/core/pal_group.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pal_group - first level of the read gather
// Registers the OR of one group of cell read terms.
// ----------------------------------------------------------------------------
module pal_group (
   input  wire logic                     clock,
   input  wire pal_pkg::group_terms_type terms,
   output pal_pkg::data_type             group_or
);

   pal_pkg::data_type or_ff;
   pal_pkg::data_type or_in;

   // at most one cell in the whole chain is selected
   always_comb begin
      or_in = '0;
      for (int k = 0; k < pal_pkg::GROUP_SIZE; k++) begin
         or_in = or_in | terms[k];
      end
   end

   always_ff @(posedge clock) begin
      or_ff <= or_in;
   end

   assign group_or = or_ff;

endmodule
`default_nettype wire

FILE: rtl/core/positional_array_list.sv
`default_nettype none
// Steps: accept in IDLE, then GATHER, then COMBINE loads the response register once any earlier response is taken.
// One request at a time: req_ready is high only in IDLE, so a new request waits until the response is loaded.
// Insert and delete shift the cells from the requested position upward in the accept cycle.
// A new request is taken while an earlier response still waits.
// Reset (synchronous) clears the entry count and the handshake state;
// entries stay undefined until written.
// ----------------------------------------------------------------------------
// positional_array_list - ordered list with positional insert, delete and read
// Chain of entry cells with a group-wise registered read gather.
// ----------------------------------------------------------------------------
module positional_array_list (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire pal_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output pal_pkg::rsp_type      rsp_payload
);

   localparam int PAD = pal_pkg::NUM_GROUPS * pal_pkg::GROUP_SIZE;

   pal_pkg::state_type state_ff, state_in;
   logic [pal_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [pal_pkg::CMP_W-1:0] pos_ff, pos_in;
   pal_pkg::status_type       status_ff, status_in;
   logic [6:0]                moved_ff, moved_in;
   logic                      good_read_ff, good_read_in;
   pal_pkg::rsp_type          rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic                      req_fire;
   logic                      rsp_load;
   logic                      ins_ok, del_ok;
   logic [pal_pkg::CMP_W-1:0] pos_ext, cnt_ext;
   pal_pkg::data_type         store_val;
   pal_pkg::data_type         read_word;

   pal_pkg::cell_ctrl_type [pal_pkg::CAPACITY-1:0] ctrl;
   pal_pkg::data_type [pal_pkg::CAPACITY-1:0]      cell_data;
   pal_pkg::data_type [PAD-1:0]                    terms;
   pal_pkg::data_type [pal_pkg::NUM_GROUPS-1:0]    group_or;

   assign req_fire  = req_valid && req_ready;
   assign pos_ext   = pal_pkg::CMP_W'(req_payload.position);
   assign cnt_ext   = pal_pkg::CMP_W'(cnt_ff);
   assign store_val = pal_pkg::DATA_WIDTH'(req_payload.value_in);

   // request checks against the current count
   always_comb begin
      ins_ok = 1'b0;
      del_ok = 1'b0;
      if (req_fire) begin
         if (req_payload.cmd == pal_pkg::CMD_INSERT) begin
            ins_ok = (cnt_ff != pal_pkg::CNT_W'(pal_pkg::CAPACITY)) && (pos_ext <= cnt_ext);
         end
         if (req_payload.cmd == pal_pkg::CMD_DELETE) begin
            del_ok = pos_ext < cnt_ext;
         end
      end
   end

   // cell chain: shift controls by index compare, read select by held position
   for (genvar i = 0; i < pal_pkg::CAPACITY; i++) begin : g_cell
      localparam logic [pal_pkg::CMP_W-1:0] IDX = pal_pkg::CMP_W'(i);
      pal_pkg::data_type below_d, above_d;

      assign ctrl[i].load       = ins_ok && (IDX == pos_ext);
      assign ctrl[i].from_below = ins_ok && (IDX > pos_ext);
      assign ctrl[i].from_above = del_ok && (IDX >= pos_ext);
      assign ctrl[i].sel        = (IDX == pos_ff);

      if (i == 0) begin : g_bot
         assign below_d = '0;
      end else begin : g_mid_b
         assign below_d = cell_data[i-1];
      end
      if (i == pal_pkg::CAPACITY - 1) begin : g_top
         assign above_d = '0;
      end else begin : g_mid_a
         assign above_d = cell_data[i+1];
      end

      pal_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl[i]),
         .value     (store_val),
         .below     (below_d),
         .above     (above_d),
         .data      (cell_data[i]),
         .read_term (terms[i])
      );
   end

   // unused slots of the last group read as zero
   for (genvar j = pal_pkg::CAPACITY; j < PAD; j++) begin : g_pad
      assign terms[j] = '0;
   end

   // first gather level
   for (genvar g = 0; g < pal_pkg::NUM_GROUPS; g++) begin : g_group
      pal_group u_group (
         .clock    (clock),
         .terms    (terms[g*pal_pkg::GROUP_SIZE +: pal_pkg::GROUP_SIZE]),
         .group_or (group_or[g])
      );
   end

   // second gather level
   always_comb begin
      read_word = '0;
      for (int g = 0; g < pal_pkg::NUM_GROUPS; g++) begin
         read_word = read_word | group_or[g];
      end
   end

   // result fields decided at accept
   always_comb begin
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      status_in    = status_ff;
      moved_in     = moved_ff;
      good_read_in = good_read_ff;
      if (req_fire) begin
         pos_in       = pos_ext;
         status_in    = pal_pkg::STATUS_OK;
         moved_in     = '0;
         good_read_in = 1'b0;
         case (req_payload.cmd)
            pal_pkg::CMD_INSERT: begin
               if (cnt_ff == pal_pkg::CNT_W'(pal_pkg::CAPACITY)) begin
                  status_in = pal_pkg::STATUS_FULL;
               end else if (!ins_ok) begin
                  status_in = pal_pkg::STATUS_RANGE;
               end else begin
                  moved_in = 7'(cnt_ext - pos_ext);
                  cnt_in   = cnt_ff + pal_pkg::CNT_W'(1);
               end
            end
            pal_pkg::CMD_DELETE: begin
               if (!del_ok) begin
                  status_in = pal_pkg::STATUS_RANGE;
               end else begin
                  moved_in = 7'(cnt_ext - pos_ext - pal_pkg::CMP_W'(1));
                  cnt_in   = cnt_ff - pal_pkg::CNT_W'(1);
               end
            end
            pal_pkg::CMD_READ: begin
               if (pos_ext < cnt_ext) begin
                  good_read_in = 1'b1;
               end else begin
                  status_in = pal_pkg::STATUS_RANGE;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // sequencer: next state and handshake
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         pal_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = pal_pkg::ST_GATHER;
            end
         end
         pal_pkg::ST_GATHER: begin
            state_in = pal_pkg::ST_COMBINE;
         end
         pal_pkg::ST_COMBINE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = pal_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pal_pkg::ST_IDLE;
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (rsp_load) begin
         rsp_in.status    = status_ff;
         rsp_in.moved     = moved_ff;
         rsp_in.count     = 8'(cnt_ff);
         rsp_in.value_out = good_read_ff ? 32'($signed(read_word)) : '0;
         rsp_valid_in     = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pal_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      status_ff    <= status_in;
      moved_ff     <= moved_in;
      good_read_ff <= good_read_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

FILE: rtl/core/pal_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pal_checker - port-level checks of the positional array list
// Watches the request and response channels over time.
// ----------------------------------------------------------------------------
module pal_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire pal_pkg::req_type req_payload,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire pal_pkg::rsp_type rsp_payload
);

   localparam logic [7:0] FULL_CNT = 8'(pal_pkg::CAPACITY);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // one request in flight: no accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   // a rejected request reports nothing moved and no data
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status != pal_pkg::STATUS_OK)
      |-> (rsp_payload.moved == '0) && (rsp_payload.value_out == '0))
      else $error("error response carries data");

   // a full rejection only when the list holds its capacity
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == pal_pkg::STATUS_FULL)
      |-> rsp_payload.count == FULL_CNT)
      else $error("full status with count below capacity");

endmodule

bind positional_array_list pal_checker u_pal_checker (.*);
`default_nettype wire
